// ===== design/complex_accumulator_alu_unit_assert.svh =====
// Assertion macros for the complex accumulator ALU.
`ifndef COMPLEX_ACCUMULATOR_ALU_UNIT_ASSERT_SVH
`define COMPLEX_ACCUMULATOR_ALU_UNIT_ASSERT_SVH

// Implication checked on every clock edge while out of reset.
`define CAA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CAA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/caa_pkg.sv =====
`timescale 1ns / 1ps
package caa_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_QUO,
    ST_DIVR,
    ST_DIVI,
    ST_CVT,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       simple;
    logic [1:0] mul_sel;
    logic       mul_en;
    logic       sum;
    logic       quo_start;
    logic       div_start;
    logic       div_step;
    logic       div_sel_imag;
    logic       div_store;
    logic       cvt;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] mode;
    logic       den_zero;
    logic       div_last;
  } dp_sts_t;

  // quotient bits per part: 66-bit magnitude with 17 fraction bits
  localparam int unsigned DivSteps = 83;

endpackage

// ===== design/caa_if.sv =====
`timescale 1ns / 1ps
interface caa_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  mode;
  logic signed [31:0] operand_real;
  logic signed [31:0] operand_imag;
  modport source (output valid, mode, operand_real, operand_imag, input ready);
  modport sink (input valid, mode, operand_real, operand_imag, output ready);
endinterface

interface caa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_real;
  logic signed [31:0] result_imag;
  logic               saturated;
  logic               divide_by_zero;
  modport source (output valid, result_real, result_imag, saturated, divide_by_zero,
                  input ready);
  modport sink (input valid, result_real, result_imag, saturated, divide_by_zero,
                output ready);
endinterface

// ===== design/complex_accumulator_alu_unit.sv =====
`timescale 1ns / 1ps
// Complex accumulator ALU, Q16.16. One request at a time; the next request is
// taken in the cycle after the result is taken. Load, add, subtract and the
// unused modes register their result in MUL0 and offer it in DONE; multiply
// and divide pass MUL0-MUL3 (one 32x32 multiplier shared over four partial
// products) and SUM, then CVT or QUO; a divide by a nonzero value goes on to DIVR
// and DIVI, a restoring bit-serial divider that forms the real and then the
// imaginary quotient, one bit a cycle over 83 bits. A result holds until taken.
module complex_accumulator_alu_unit (
  input logic clk,
  input logic rst_n,
  caa_in_if.sink    in_ch,
  caa_out_if.source out_ch
);
  import caa_pkg::*;
  `include "complex_accumulator_alu_unit_assert.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  caa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  caa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_ch.mode), .in_operand_real(in_ch.operand_real),
    .in_operand_imag(in_ch.operand_imag),
    .out_result_real(out_ch.result_real), .out_result_imag(out_ch.result_imag),
    .out_saturated(out_ch.saturated), .out_divide_by_zero(out_ch.divide_by_zero)
  );

  `CAA_ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ch.ready, !out_ch.valid)
  `CAA_ASSERT_IMPL(a_dz_no_sat, clk, rst_n, out_ch.valid && out_ch.divide_by_zero,
                   !out_ch.saturated)
  `CAA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

// ===== design/caa_ctrl.sv =====
`timescale 1ns / 1ps
module caa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  caa_pkg::dp_sts_t  sts,
  output caa_pkg::dp_cmd_t  cmd
);
  import caa_pkg::*;

  state_t state_r, state_nxt;
  logic   imag_r, imag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      imag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      imag_r  <= imag_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    imag_nxt  = imag_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL0;
      ST_MUL0: begin
        if (sts.mode == MODE_MUL || sts.mode == MODE_DIV) state_nxt = ST_MUL1;
        else state_nxt = ST_DONE;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_SUM;
      ST_SUM: begin
        if (sts.mode == MODE_MUL) state_nxt = ST_CVT;
        else state_nxt = ST_QUO;
      end
      ST_QUO: begin
        if (sts.den_zero) state_nxt = ST_DONE;
        else begin
          state_nxt = ST_DIVR;
          imag_nxt  = 1'b0;
        end
      end
      ST_DIVR: if (sts.div_last) state_nxt = ST_DIVI;
      ST_DIVI: if (sts.div_last) state_nxt = ST_DONE;
      ST_CVT:  state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MUL0: begin
        cmd.simple  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd0;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd1;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd2;
      end
      ST_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd3;
      end
      ST_SUM: cmd.sum = 1'b1;
      ST_QUO: begin
        cmd.quo_start = 1'b1;
        cmd.div_start = !sts.den_zero;
      end
      ST_DIVR: begin
        cmd.div_step  = 1'b1;
        cmd.div_store = sts.div_last;
        cmd.div_start = sts.div_last;
      end
      ST_DIVI: begin
        cmd.div_step     = 1'b1;
        cmd.div_sel_imag = 1'b1;
        cmd.div_store    = sts.div_last;
      end
      ST_CVT: begin
        cmd.cvt = 1'b1;
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/caa_dp.sv =====
`timescale 1ns / 1ps
module caa_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  caa_pkg::dp_cmd_t   cmd,
  output caa_pkg::dp_sts_t   sts,
  input  logic        [2:0]  in_mode,
  input  logic signed [31:0] in_operand_real,
  input  logic signed [31:0] in_operand_imag,
  output logic signed [31:0] out_result_real,
  output logic signed [31:0] out_result_imag,
  output logic               out_saturated,
  output logic               out_divide_by_zero
);
  import caa_pkg::*;

  localparam logic signed [31:0] SMax = 32'sh7fffffff;
  localparam logic signed [31:0] SMin = 32'sh80000000;

  logic        [2:0]  mode_r;
  logic signed [31:0] br_r, bi_r;
  logic signed [31:0] acc_re_r, acc_im_r;
  logic signed [31:0] res_re_r, res_im_r;
  logic               sat_r, dz_r;
  logic signed [63:0] p_r [4];
  logic signed [65:0] nre_r, nim_r;
  logic        [64:0] den_r;
  logic        [65:0] rem_r;
  logic        [82:0] q_r;
  logic        [6:0]  cnt_r;
  logic               neg_r;
  logic signed [31:0] dre_r;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] sum_re, sum_im;
  logic               sat_add;
  logic signed [66:0] trial;
  logic        [65:0] rem_sh;
  logic        [83:0] qrnd;
  logic signed [31:0] qval;
  logic               qsat;
  logic        [65:0] mre, mim;
  logic        [49:0] rre, rim;
  logic signed [31:0] cre, cim;
  logic               cre_sat, cim_sat;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v,
                                               output logic s);
    s = 1'b0;
    if (v > 33'sh07fffffff) begin
      s = 1'b1;
      return SMax;
    end else if (v < -33'sh080000000) begin
      s = 1'b1;
      return SMin;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] cvt50(input logic neg, input logic [49:0] m,
                                               output logic s);
    s = 1'b0;
    if (!neg && m > 50'h7fffffff) begin
      s = 1'b1;
      return SMax;
    end else if (neg && m > 50'h80000000) begin
      s = 1'b1;
      return SMin;
    end
    return neg ? -m[31:0] : m[31:0];
  endfunction

  always_comb begin
    unique case (cmd.mul_sel)
      2'd0: begin ma = acc_re_r; mb = br_r; end
      2'd1: begin ma = acc_im_r; mb = bi_r; end
      2'd2: begin ma = acc_re_r; mb = bi_r; end
      default: begin ma = acc_im_r; mb = br_r; end
    endcase
    prod = ma * mb;
  end

  logic s1, s2;
  always_comb begin
    sum_re  = '0;
    sum_im  = '0;
    s1      = 1'b0;
    s2      = 1'b0;
    unique case (mode_r)
      MODE_LOAD: begin sum_re = br_r; sum_im = bi_r; end
      MODE_ADD: begin
        sum_re = sat33(33'(acc_re_r) + 33'(br_r), s1);
        sum_im = sat33(33'(acc_im_r) + 33'(bi_r), s2);
      end
      MODE_SUB: begin
        sum_re = sat33(33'(acc_re_r) - 33'(br_r), s1);
        sum_im = sat33(33'(acc_im_r) - 33'(bi_r), s2);
      end
      default: begin sum_re = acc_re_r; sum_im = acc_im_r; end
    endcase
    sat_add = s1 | s2;
  end

  assign mre = nre_r[65] ? 66'(-nre_r) : 66'(nre_r);
  assign mim = nim_r[65] ? 66'(-nim_r) : 66'(nim_r);
  assign rre = 50'(mre[65:16]) + 50'(mre[15]);
  assign rim = 50'(mim[65:16]) + 50'(mim[15]);

  always_comb begin
    cre = cvt50(nre_r[65], rre, cre_sat);
    cim = cvt50(nim_r[65], rim, cim_sat);
  end

  assign rem_sh  = {rem_r[64:0], q_r[82]};
  assign trial   = 67'(rem_sh) - 67'(den_r);

  // quotient carries 17 fraction bits; drop one with rounding
  assign qrnd = (84'(q_r) + 84'd1) >> 1;
  always_comb begin
    qsat = 1'b0;
    if (q_r[82:33] != '0) begin
      qsat = 1'b1;
      qval = neg_r ? SMin : SMax;
    end else if (!neg_r && qrnd > 84'h7fffffff) begin
      qsat = 1'b1;
      qval = SMax;
    end else if (neg_r && qrnd > 84'h80000000) begin
      qsat = 1'b1;
      qval = SMin;
    end else begin
      qval = neg_r ? -qrnd[31:0] : qrnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.capture) begin
        mode_r <= in_mode;
        br_r   <= in_operand_real;
        bi_r   <= in_operand_imag;
        sat_r  <= 1'b0;
        dz_r   <= 1'b0;
      end
      if (cmd.simple && mode_r != MODE_MUL && mode_r != MODE_DIV) begin
        acc_re_r <= sum_re;
        acc_im_r <= sum_im;
        res_re_r <= sum_re;
        res_im_r <= sum_im;
        sat_r    <= sat_add;
      end
      if (cmd.simple && mode_r == MODE_DIV) begin
        res_re_r <= acc_re_r;
        res_im_r <= acc_im_r;
      end
      if (cmd.mul_en) p_r[cmd.mul_sel] <= prod;
      if (cmd.sum) begin
        if (mode_r == MODE_MUL) begin
          nre_r <= 66'(p_r[0]) - 66'(p_r[1]);
          nim_r <= 66'(p_r[2]) + 66'(p_r[3]);
        end else begin
          nre_r <= 66'(p_r[0]) + 66'(p_r[1]);
          nim_r <= 66'(p_r[3]) - 66'(p_r[2]);
        end
        den_r <= 65'(64'(br_r * br_r)) + 65'(64'(bi_r * bi_r));
      end
      if (cmd.quo_start && sts.den_zero) dz_r <= 1'b1;
      // restart during a step cycle loads the imaginary part
      if (cmd.div_start) begin
        q_r   <= cmd.div_step ? {mim, 17'd0} : {mre, 17'd0};
        rem_r <= '0;
        neg_r <= cmd.div_step ? nim_r[65] : nre_r[65];
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        rem_r <= trial[66] ? rem_sh : trial[65:0];
        q_r   <= {q_r[81:0], !trial[66]};
        cnt_r <= cnt_r + 7'd1;
      end
      if (cmd.div_store && !cmd.div_sel_imag) dre_r <= qval;
      if (cmd.div_store) sat_r <= sat_r | qsat;
      if (cmd.div_store && cmd.div_sel_imag) begin
        acc_re_r <= dre_r;
        acc_im_r <= qval;
        res_re_r <= dre_r;
        res_im_r <= qval;
      end
      if (cmd.cvt) begin
        acc_re_r <= cre;
        acc_im_r <= cim;
        res_re_r <= cre;
        res_im_r <= cim;
        sat_r    <= cre_sat | cim_sat;
      end
    end
  end

  assign sts.mode     = mode_r;
  assign sts.den_zero = (den_r == '0);
  assign sts.div_last = (cnt_r == 7'(DivSteps));

  assign out_result_real    = res_re_r;
  assign out_result_imag    = res_im_r;
  assign out_saturated      = sat_r;
  assign out_divide_by_zero = dz_r;

endmodule
